FILE: rtl/qwr_pkg.sv
// shared constants for the quaternion w reconstruction block
`default_nettype none

package qwr_pkg;

  // component width, signed q1.15 on the ports
  localparam int unsigned QW = 16;

  // default number of fraction bits
  localparam int unsigned FRAC_BITS_DEF = 15;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 3 * QW;
  localparam int unsigned OUT_TDATA_W = QW;

  // largest root magnitude that fits the output (gives -32768)
  localparam int unsigned W_SAT = 32768;

endpackage

`default_nettype wire

FILE: rtl/qwr_front.sv
// squaring stage and remainder stage: forms t = one - x^2 - y^2 - z^2
`default_nettype none

module qwr_front #(
  parameter int unsigned FRAC_BITS = qwr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output      logic                                   in_ready,
  input  wire logic signed [qwr_pkg::QW-1:0]          quat_x,
  input  wire logic signed [qwr_pkg::QW-1:0]          quat_y,
  input  wire logic signed [qwr_pkg::QW-1:0]          quat_z,
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic [2*(FRAC_BITS+1)-1:0]             rad,
  output      logic                                   clamp
);

  import qwr_pkg::*;

  localparam int unsigned RW    = FRAC_BITS + 1;
  localparam int unsigned RAD_W = 2 * RW;
  localparam int unsigned SQ_W  = 2 * QW - 1;
  localparam int unsigned SUM_W = 2 * QW;
  localparam int unsigned SW    = ((RAD_W > SUM_W + 1) ? RAD_W : (SUM_W + 1)) + 1;
  localparam logic [SW-1:0] ONE_V = {{(SW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

  logic                  v1_r;
  logic                  v2_r;
  logic                  rdy1;
  logic                  rdy2;
  logic [SQ_W-1:0]       sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_W-1:0]       sq_x_nxt, sq_y_nxt, sq_z_nxt;
  logic signed [SUM_W-1:0] px, py, pz;
  logic [SUM_W-1:0]      sum;
  logic [SW-1:0]         t_val;
  logic [RAD_W-1:0]      rad_r, rad_nxt;
  logic                  clamp_r, clamp_nxt;

  // stage readiness, bubbles are filled
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // squares, each at most 2^30 so the sign bit drops
  always_comb begin
    px       = SUM_W'(quat_x) * SUM_W'(quat_x);
    py       = SUM_W'(quat_y) * SUM_W'(quat_y);
    pz       = SUM_W'(quat_z) * SUM_W'(quat_z);
    sq_x_nxt = px[SQ_W-1:0];
    sq_y_nxt = py[SQ_W-1:0];
    sq_z_nxt = pz[SQ_W-1:0];
  end

  // remainder below one, sign gives the clamp
  always_comb begin
    sum       = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
    t_val     = ONE_V - SW'(sum);
    clamp_nxt = t_val[SW-1];
    rad_nxt   = clamp_nxt ? '0 : t_val[RAD_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sq_x_r <= sq_x_nxt;
      sq_y_r <= sq_y_nxt;
      sq_z_r <= sq_z_nxt;
    end
    if (rdy2 && v1_r) begin
      rad_r   <= rad_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  assign out_valid = v2_r;
  assign rad       = rad_r;
  assign clamp     = clamp_r;

endmodule

`default_nettype wire

FILE: rtl/qwr_sqrt_pipe.sv
// truncating square root, one root bit per pipeline stage
`default_nettype none

module qwr_sqrt_pipe #(
  parameter int unsigned FRAC_BITS = qwr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [2*(FRAC_BITS+1)-1:0]   rad,
  input  wire logic                         clamp_in,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [FRAC_BITS:0]           root,
  output      logic                         clamp_out
);

  import qwr_pkg::*;

  localparam int unsigned RW    = FRAC_BITS + 1;
  localparam int unsigned RAD_W = 2 * RW;

  logic             v_r   [RW];
  logic [RAD_W-1:0] rem_r [RW];
  logic [RW-1:0]    q_r   [RW];
  logic             cl_r  [RW];
  logic             rdy   [RW];

  genvar i;
  for (i = 0; i < RW; i++) begin : g_bit
    localparam int unsigned K = RW - 1 - i;

    logic             v_in;
    logic [RAD_W-1:0] rem_in;
    logic [RW-1:0]    q_in;
    logic             cl_in;
    logic             rdy_dn;
    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] rem_nxt;
    logic [RW-1:0]    q_nxt;

    // stage inputs
    if (i == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = rad;
      assign q_in   = '0;
      assign cl_in  = clamp_in;
    end else begin : g_body
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign cl_in  = cl_r[i-1];
    end

    // readiness from the stage below
    if (i == RW - 1) begin : g_tail
      assign rdy_dn = out_ready;
    end else begin : g_link
      assign rdy_dn = rdy[i+1];
    end
    assign rdy[i] = !v_r[i] || rdy_dn;

    // trial value 2*q*2^k + 2^(2k), then compare and subtract
    always_comb begin
      trial   = (RAD_W'(q_in) << (K + 1)) | (RAD_W'(1'b1) << (2 * K));
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        q_nxt   = q_in | (RW'(1'b1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && v_in) begin
        rem_r[i] <= rem_nxt;
        q_r[i]   <= q_nxt;
        cl_r[i]  <= cl_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[RW-1];
  assign root      = q_r[RW-1];
  assign clamp_out = cl_r[RW-1];

endmodule

`default_nettype wire

FILE: rtl/qwr_out_stage.sv
// saturation, negation and the output register
`default_nettype none

module qwr_out_stage #(
  parameter int unsigned FRAC_BITS = qwr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [FRAC_BITS:0]            root,
  input  wire logic                          clamp_in,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic signed [qwr_pkg::QW-1:0] quat_w,
  output      logic                          clamped
);

  import qwr_pkg::*;

  localparam int unsigned RW = FRAC_BITS + 1;
  localparam int unsigned MW = QW + 1;
  localparam int unsigned EW = (RW > MW) ? RW : MW;

  logic              v_r;
  logic [EW-1:0]     root_ext;
  logic [MW-1:0]     mag;
  logic [MW-1:0]     neg;
  logic [QW-1:0]     w_r, w_nxt;
  logic              cl_r;

  assign in_ready = !v_r || out_ready;

  // clip the root at 32768 and negate, a clamped item already has root zero
  always_comb begin
    root_ext = EW'(root);
    if (root_ext > EW'(W_SAT)) begin
      mag = MW'(W_SAT);
    end else begin
      mag = root_ext[MW-1:0];
    end
    neg   = MW'(0) - mag;
    w_nxt = neg[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      w_r  <= w_nxt;
      cl_r <= clamp_in;
    end
  end

  assign out_valid = v_r;
  assign quat_w    = w_r;
  assign clamped   = cl_r;

endmodule

`default_nettype wire

FILE: rtl/quaternion_w_reconstruct_core.sv
// top level: rebuilds w = -floor(sqrt(one - x^2 - y^2 - z^2)) from a stream of x, y, z
// throughput: one beat per cycle while the output is not stalled
// one register stage per root bit plus squares, t and output
// every stage has its own valid bit, so bubbles close up while the output is stalled
// reset (synchronous, active low) clears all valid bits, data registers are not reset
`default_nettype none

module quaternion_w_reconstruct_core #(
  parameter int unsigned FRAC_BITS = qwr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // quat_x [15:0], quat_y [31:16], quat_z [47:32]
  input  wire logic [qwr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // quat_w [15:0]
  output      logic [qwr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // clamped [0]
  output      logic                              out_tuser
);

  import qwr_pkg::*;

  localparam int unsigned RW    = FRAC_BITS + 1;
  localparam int unsigned RAD_W = 2 * RW;

  logic signed [QW-1:0] quat_x, quat_y, quat_z;
  logic                 f_valid, f_ready, f_clamp;
  logic [RAD_W-1:0]     f_rad;
  logic                 s_valid, s_ready, s_clamp;
  logic [RW-1:0]        s_root;
  logic signed [QW-1:0] quat_w;

  // unpack the input beat
  assign quat_x = in_tdata[QW-1:0];
  assign quat_y = in_tdata[2*QW-1:QW];
  assign quat_z = in_tdata[3*QW-1:2*QW];

  qwr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .rad       (f_rad),
    .clamp     (f_clamp)
  );

  qwr_sqrt_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .rad       (f_rad),
    .clamp_in  (f_clamp),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .root      (s_root),
    .clamp_out (s_clamp)
  );

  qwr_out_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .root      (s_root),
    .clamp_in  (s_clamp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .quat_w    (quat_w),
    .clamped   (out_tuser)
  );

  assign out_tdata = quat_w;

endmodule

`default_nettype wire

FILE: rtl/qwr_checker.sv
// port-level checks for the quaternion w reconstruction core, with bind
`default_nettype none

module qwr_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [qwr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [qwr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tuser
);

  import qwr_pkg::*;

  // a stalled input beat keeps its data
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a clamped result carries w of zero
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("clamped beat with nonzero w");

  // w is never positive
  a_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1] || out_tdata == '0)
    else $error("positive w on output");

  // nothing left in flight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat straight after reset");

endmodule

bind quaternion_w_reconstruct_core qwr_checker u_qwr_checker (.*);

`default_nettype wire
